/* hw/rtl/rotate_vector_and_tensor_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the rotate vector and tensor unit
// Shorthand for clocked implication checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ROTATE_VECTOR_AND_TENSOR_UNIT_ASSERT_SVH
`define ROTATE_VECTOR_AND_TENSOR_UNIT_ASSERT_SVH

// Overlapping implication: the consequent is checked on the same edge.
`define RVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rotate unit check failed");

// Next-cycle implication: the consequent is checked on the edge after the antecedent.
`define RVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rotate unit check failed");

`endif

/* hw/rtl/rvt_pkg.sv */
// ----------------------------------------------------------------------------
// rvt_pkg
// Shared types, codes and constants of the rotate vector and tensor unit.
// ----------------------------------------------------------------------------
package rvt_pkg;

	typedef enum logic [1:0] {
		REQ_VEC_FWD = 2'd0,
		REQ_VEC_INV = 2'd1,
		REQ_TEN_FWD = 2'd2,
		REQ_TEN_INV = 2'd3
	} req_t;

	localparam int NUM_AXES  = 3;
	localparam int NUM_COMPS = 6;

	localparam int REG_IDX_BITS = 2;
	typedef logic [REG_IDX_BITS-1:0] reg_idx_t;
	localparam reg_idx_t REG_ROW_ZERO = 2'd0;
	localparam reg_idx_t REG_ROW_ONE  = 2'd1;
	localparam reg_idx_t REG_ROW_TWO  = 2'd2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = 1;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

	// Component order is xx, yy, zz, xy, xz, yz: each index names an axis pair.
	function automatic int pair_row(input int idx);
		unique case (idx) inside
			0, 3, 4: return 0;
			1, 5:    return 1;
			default: return 2;
		endcase
	endfunction

	function automatic int pair_col(input int idx);
		unique case (idx) inside
			0:       return 0;
			1, 3:    return 1;
			default: return 2;
		endcase
	endfunction

	// One queue entry: op flag, six data words, 6x6 combined coefficients.
	function automatic int entry_width(input int data_bits, input int coef_bits);
		return 1 + NUM_COMPS * data_bits + NUM_COMPS * NUM_COMPS * (2 * coef_bits + 1);
	endfunction

endpackage

/* hw/rtl/rotate_vector_and_tensor_unit.sv */
// ----------------------------------------------------------------------------
// rotate_vector_and_tensor_unit
// Applies a programmed 3x3 matrix R to a vector (R*v or R'*v) or to a
// symmetric tensor (R*T*R' or R'*T*R), rounding and saturating each result.
//
// Matrix rows are written through wr_en / wr_index / wr_data, one row of
// three Q2.16 entries per write; reset loads the identity matrix. Rows must
// only change while no request is in flight.
// A request beat is taken on a clock edge with start high and busy low. The
// result beat appears on out_a..out_f and saturated with done high for one
// cycle. A new request can be taken every cycle while busy is low: the front
// end forms the coefficient set, a two-entry queue holds it, and a five-stage
// multiply-accumulate back end finishes one beat per cycle.
// The receiver has no way to stall, so the back end always drains the queue
// and busy stays low in normal use. Reset empties the queue and the pipeline;
// beats in flight are dropped.
// ----------------------------------------------------------------------------
module rotate_vector_and_tensor_unit
	import rvt_pkg::*;
#(
	parameter int DATA_BITS      = 32,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [1:0]                             req_type,
	input  logic signed [DATA_BITS-1:0]            comp_a,
	input  logic signed [DATA_BITS-1:0]            comp_b,
	input  logic signed [DATA_BITS-1:0]            comp_c,
	input  logic signed [DATA_BITS-1:0]            comp_d,
	input  logic signed [DATA_BITS-1:0]            comp_e,
	input  logic signed [DATA_BITS-1:0]            comp_f,
	input  logic                                   wr_en,
	input  reg_idx_t                               wr_index,
	input  logic [NUM_AXES*(COEF_FRAC_BITS+2)-1:0] wr_data,
	output logic                                   done,
	output logic signed [DATA_BITS-1:0]            out_a,
	output logic signed [DATA_BITS-1:0]            out_b,
	output logic signed [DATA_BITS-1:0]            out_c,
	output logic signed [DATA_BITS-1:0]            out_d,
	output logic signed [DATA_BITS-1:0]            out_e,
	output logic signed [DATA_BITS-1:0]            out_f,
	output logic                                   saturated
);

	localparam int ENTRY_W = entry_width(DATA_BITS, COEF_FRAC_BITS + 2);

	logic               push;
	logic               pop;
	logic [ENTRY_W-1:0] push_data;
	logic [ENTRY_W-1:0] head_data;
	q_stat_t            qstat;

	rvt_front #(
		.DATA_BITS      (DATA_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.comp_a    (comp_a),
		.comp_b    (comp_b),
		.comp_c    (comp_c),
		.comp_d    (comp_d),
		.comp_e    (comp_e),
		.comp_f    (comp_f),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	rvt_queue #(
		.WIDTH (ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head_data (head_data),
		.qstat     (qstat)
	);

	rvt_back #(
		.DATA_BITS      (DATA_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head_data (head_data),
		.pop       (pop),
		.done      (done),
		.out_a     (out_a),
		.out_b     (out_b),
		.out_c     (out_c),
		.out_d     (out_d),
		.out_e     (out_e),
		.out_f     (out_f),
		.saturated (saturated)
	);

endmodule

/* hw/rtl/rvt_front.sv */
// ----------------------------------------------------------------------------
// rvt_front
// Holds the matrix rows, accepts requests and turns each one into a 6x6
// coefficient set over the six input components, pushed into the queue.
// ----------------------------------------------------------------------------
module rvt_front
	import rvt_pkg::*;
#(
	parameter int DATA_BITS      = 32,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           start,
	output logic                                           busy,
	input  logic [1:0]                                     req_type,
	input  logic signed [DATA_BITS-1:0]                    comp_a,
	input  logic signed [DATA_BITS-1:0]                    comp_b,
	input  logic signed [DATA_BITS-1:0]                    comp_c,
	input  logic signed [DATA_BITS-1:0]                    comp_d,
	input  logic signed [DATA_BITS-1:0]                    comp_e,
	input  logic signed [DATA_BITS-1:0]                    comp_f,
	input  logic                                           wr_en,
	input  reg_idx_t                                       wr_index,
	input  logic [NUM_AXES*(COEF_FRAC_BITS+2)-1:0]         wr_data,
	input  q_stat_t                                        qstat,
	output logic                                           push,
	output logic [entry_width(DATA_BITS, COEF_FRAC_BITS+2)-1:0] push_data
);

	localparam int CW        = COEF_FRAC_BITS + 2;
	localparam int RW        = NUM_AXES * CW;
	localparam int CPW       = 2 * CW + 1;
	localparam int ENTRY_W   = entry_width(DATA_BITS, CW);
	localparam int DATA_BASE = NUM_COMPS * NUM_COMPS * CPW;

	logic [RW-1:0]               row_q [NUM_AXES];
	logic                        valid_s1;
	req_t                        req_s1;
	logic signed [DATA_BITS-1:0] comp_s1 [NUM_COMPS];
	logic                        accept;
	logic                        inverse;
	logic                        tensor;
	logic signed [CW-1:0]        m [NUM_AXES][NUM_AXES];
	logic signed [CPW-1:0]       coef [NUM_COMPS][NUM_COMPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				row_q[i] <= RW'(1) << (CW * i + COEF_FRAC_BITS);
			end
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ROW_ZERO: row_q[0] <= wr_data;
				REG_ROW_ONE:  row_q[1] <= wr_data;
				REG_ROW_TWO:  row_q[2] <= wr_data;
				default: ;
			endcase
		end
	end

	assign accept = start && !busy;
	assign push   = valid_s1 && !qstat.full;
	assign busy   = valid_s1 && qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1     <= req_t'(req_type);
			comp_s1[0] <= comp_a;
			comp_s1[1] <= comp_b;
			comp_s1[2] <= comp_c;
			comp_s1[3] <= comp_d;
			comp_s1[4] <= comp_e;
			comp_s1[5] <= comp_f;
		end
	end

	assign inverse = (req_s1 == REQ_VEC_INV) || (req_s1 == REQ_TEN_INV);
	assign tensor  = (req_s1 == REQ_TEN_FWD) || (req_s1 == REQ_TEN_INV);

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			for (int k = 0; k < NUM_AXES; k++) begin
				m[i][k] = inverse ? $signed(row_q[k][CW*i +: CW])
				                  : $signed(row_q[i][CW*k +: CW]);
			end
		end
	end

	// A tensor result (a,b) weights component (p,q) by m[a][p]*m[b][q], with the
	// mirrored product added for the off-diagonal components.
	always_comb begin
		int a, b, p, q;
		logic signed [2*CW-1:0] prod_a, prod_b;
		logic signed [CPW-1:0]  ten_coef, vec_coef;
		a = 0;
		b = 0;
		p = 0;
		q = 0;
		prod_a = '0;
		prod_b = '0;
		ten_coef = '0;
		vec_coef = '0;
		for (int j = 0; j < NUM_COMPS; j++) begin
			for (int t = 0; t < NUM_COMPS; t++) begin
				a = pair_row(j);
				b = pair_col(j);
				p = pair_row(t);
				q = pair_col(t);
				prod_a = m[a][p] * m[b][q];
				if (t < NUM_AXES) begin
					prod_b = '0;
				end else begin
					prod_b = m[a][q] * m[b][p];
				end
				ten_coef = CPW'(prod_a) + CPW'(prod_b);
				if (j < NUM_AXES && t < NUM_AXES) begin
					vec_coef = CPW'(m[j][t]);
				end else begin
					vec_coef = '0;
				end
				coef[j][t] = tensor ? ten_coef : vec_coef;
			end
		end
	end

	always_comb begin
		push_data = '0;
		push_data[ENTRY_W-1] = tensor;
		for (int j = 0; j < NUM_COMPS; j++) begin
			push_data[DATA_BASE + j*DATA_BITS +: DATA_BITS] = comp_s1[j];
			for (int t = 0; t < NUM_COMPS; t++) begin
				push_data[(j*NUM_COMPS + t)*CPW +: CPW] = coef[j][t];
			end
		end
	end

endmodule

/* hw/rtl/rvt_queue.sv */
// ----------------------------------------------------------------------------
// rvt_queue
// Short FIFO between the request front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module rvt_queue
	import rvt_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output q_stat_t          qstat
);

	logic [WIDTH-1:0]     mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign qstat.full     = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign qstat.nonempty = (count_q != '0);
	assign do_push        = push && !qstat.full;
	assign do_pop         = pop && qstat.nonempty;
	assign head_data      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/rvt_back.sv */
// ----------------------------------------------------------------------------
// rvt_back
// Multiply-accumulate pipeline: partial products, term assembly, pair sums,
// final sum with rounding offset, then shift and saturation to the outputs.
// ----------------------------------------------------------------------------
module rvt_back
	import rvt_pkg::*;
#(
	parameter int DATA_BITS      = 32,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  q_stat_t                                             qstat,
	input  logic [entry_width(DATA_BITS, COEF_FRAC_BITS+2)-1:0] head_data,
	output logic                                                pop,
	output logic                                                done,
	output logic signed [DATA_BITS-1:0]                         out_a,
	output logic signed [DATA_BITS-1:0]                         out_b,
	output logic signed [DATA_BITS-1:0]                         out_c,
	output logic signed [DATA_BITS-1:0]                         out_d,
	output logic signed [DATA_BITS-1:0]                         out_e,
	output logic signed [DATA_BITS-1:0]                         out_f,
	output logic                                                saturated
);

	localparam int CW        = COEF_FRAC_BITS + 2;
	localparam int CPW       = 2 * CW + 1;
	localparam int ENTRY_W   = entry_width(DATA_BITS, CW);
	localparam int DATA_BASE = NUM_COMPS * NUM_COMPS * CPW;
	localparam int PPW       = CW + 1 + DATA_BITS;
	localparam int PW        = CPW + DATA_BITS;
	localparam int SW        = PW + 1;
	localparam int ACC       = PW + 3;
	localparam int NPAIR     = NUM_COMPS / 2;

	localparam logic signed [ACC-1:0] HALF_VEC = ACC'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC-1:0] HALF_TEN = ACC'(1) << (2 * COEF_FRAC_BITS - 1);
	localparam logic [DATA_BITS-1:0] MAX_VAL = {1'b0, {(DATA_BITS-1){1'b1}}};
	localparam logic [DATA_BITS-1:0] MIN_VAL = {1'b1, {(DATA_BITS-1){1'b0}}};

	logic                        tensor_h;
	logic signed [DATA_BITS-1:0] d_h [NUM_COMPS];
	logic signed [CPW-CW-1:0]    coef_hi [NUM_COMPS][NUM_COMPS];
	logic signed [CW:0]          coef_lo [NUM_COMPS][NUM_COMPS];

	logic                 valid_s2, valid_s3, valid_s4, valid_s5;
	logic                 tensor_s2, tensor_s3, tensor_s4, tensor_s5;
	logic signed [PPW-1:0] hi_s2 [NUM_COMPS][NUM_COMPS];
	logic signed [PPW-1:0] lo_s2 [NUM_COMPS][NUM_COMPS];
	logic signed [PW-1:0]  term_s3 [NUM_COMPS][NUM_COMPS];
	logic signed [SW-1:0]  pair_s4 [NUM_COMPS][NPAIR];
	logic signed [ACC-1:0] sum_s5 [NUM_COMPS];

	logic signed [ACC-1:0]       shifted [NUM_COMPS];
	logic [DATA_BITS-1:0]        clipped [NUM_COMPS];
	logic [NUM_COMPS-1:0]        over;
	logic                        done_q;
	logic [DATA_BITS-1:0]        out_q [NUM_COMPS];
	logic                        sat_q;

	// The back end never stalls, so the head is taken whenever there is one.
	assign pop = qstat.nonempty;

	always_comb begin
		tensor_h = head_data[ENTRY_W-1];
		for (int t = 0; t < NUM_COMPS; t++) begin
			d_h[t] = $signed(head_data[DATA_BASE + t*DATA_BITS +: DATA_BITS]);
		end
		for (int j = 0; j < NUM_COMPS; j++) begin
			for (int t = 0; t < NUM_COMPS; t++) begin
				coef_hi[j][t] = $signed(head_data[(j*NUM_COMPS + t)*CPW + CW +: CPW-CW]);
				coef_lo[j][t] = $signed({1'b0, head_data[(j*NUM_COMPS + t)*CPW +: CW]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s2 <= pop;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			done_q   <= valid_s5;
		end
	end

	// Each coefficient is split into a signed upper half and an unsigned lower
	// half so that no single multiplier grows past the data width.
	always_ff @(posedge clk) begin
		tensor_s2 <= tensor_h;
		tensor_s3 <= tensor_s2;
		tensor_s4 <= tensor_s3;
		tensor_s5 <= tensor_s4;
		for (int j = 0; j < NUM_COMPS; j++) begin
			for (int t = 0; t < NUM_COMPS; t++) begin
				hi_s2[j][t]   <= coef_hi[j][t] * d_h[t];
				lo_s2[j][t]   <= coef_lo[j][t] * d_h[t];
				term_s3[j][t] <= (PW'(hi_s2[j][t]) <<< CW) + PW'(lo_s2[j][t]);
			end
			for (int g = 0; g < NPAIR; g++) begin
				pair_s4[j][g] <= SW'(term_s3[j][2*g]) + SW'(term_s3[j][2*g+1]);
			end
			sum_s5[j] <= ACC'(pair_s4[j][0]) + ACC'(pair_s4[j][1]) + ACC'(pair_s4[j][2])
			           + (tensor_s4 ? HALF_TEN : HALF_VEC);
		end
	end

	always_comb begin
		for (int j = 0; j < NUM_COMPS; j++) begin
			shifted[j] = tensor_s5 ? (sum_s5[j] >>> (2 * COEF_FRAC_BITS))
			                       : (sum_s5[j] >>> COEF_FRAC_BITS);
			over[j] = !((&shifted[j][ACC-1:DATA_BITS-1]) || !(|shifted[j][ACC-1:DATA_BITS-1]));
			if (!over[j]) begin
				clipped[j] = shifted[j][DATA_BITS-1:0];
			end else if (shifted[j][ACC-1]) begin
				clipped[j] = MIN_VAL;
			end else begin
				clipped[j] = MAX_VAL;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s5) begin
			for (int j = 0; j < NUM_COMPS; j++) begin
				out_q[j] <= clipped[j];
			end
			sat_q <= |over;
		end
	end

	assign done      = done_q;
	assign out_a     = $signed(out_q[0]);
	assign out_b     = $signed(out_q[1]);
	assign out_c     = $signed(out_q[2]);
	assign out_d     = $signed(out_q[3]);
	assign out_e     = $signed(out_q[4]);
	assign out_f     = $signed(out_q[5]);
	assign saturated = sat_q;

endmodule

/* hw/rtl/rvt_checker.sv */
// ----------------------------------------------------------------------------
// rvt_checker
// Port-level checks of the rotate unit: fixed latency, one result beat per
// request beat, and zero tensor-only outputs for vector requests.
// ----------------------------------------------------------------------------
`include "rotate_vector_and_tensor_unit_assert.svh"

module rvt_checker #(
	parameter int DATA_BITS = 32
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic [1:0]           req_type,
	input logic                 done,
	input logic [DATA_BITS-1:0] out_d,
	input logic [DATA_BITS-1:0] out_e,
	input logic [DATA_BITS-1:0] out_f
);

	// Every request beat returns its result beat.
	`RVT_ASSERT_IMP(a_req_gives_result, clk, arst_n, start && !busy, ##7 done)

	// No result beat without a matching earlier request beat.
	`RVT_ASSERT_IMP(a_result_has_req, clk, arst_n, done, $past(start && !busy, 7))

	// A result beat is followed by another only if a request followed too.
	`RVT_ASSERT_NEXT(a_no_repeat, clk, arst_n, done && !$past(start && !busy, 6), !done)

	// Vector requests leave the off-diagonal outputs at zero.
	`RVT_ASSERT_IMP(a_vector_zero, clk, arst_n, done && !$past(req_type[1], 7), (out_d == '0) && (out_e == '0) && (out_f == '0))

endmodule

bind rotate_vector_and_tensor_unit rvt_checker #(
	.DATA_BITS (DATA_BITS)
) u_rvt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.req_type (req_type),
	.done     (done),
	.out_d    (out_d),
	.out_e    (out_e),
	.out_f    (out_f)
);
